### hw/rtl/tasp_pkg.sv
package tasp_pkg;

	localparam int COORD_BITS = 24;
	localparam int STEP_BITS  = 16;
	localparam int BASE_BITS  = 20;
	localparam int WIDTH_BITS = 36;
	localparam int CFG_BITS   = 24;
	localparam int CFG_IDX_BITS = 3;

	// divider: step numerator is steps * distance, time numerator is steps * half period
	localparam int DVD_BITS = STEP_BITS + COORD_BITS;
	localparam int DSR_BITS = COORD_BITS;
	localparam int TIME_BITS = STEP_BITS + BASE_BITS;
	localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

	localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

	localparam logic [COORD_BITS-1:0] RANGE_DISTANCE_RST = COORD_BITS'(380000);
	localparam logic [STEP_BITS-1:0]  RANGE_STEPS_RST    = STEP_BITS'(2000);
	localparam logic [BASE_BITS-1:0]  BASE_HIGH_RST      = BASE_BITS'(20000);
	localparam logic [BASE_BITS-1:0]  BASE_LOW_RST       = BASE_BITS'(3000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_RANGE_DISTANCE = 3'd0,
		CFG_RANGE_STEPS    = 3'd1,
		CFG_BASE_HIGH      = 3'd2,
		CFG_BASE_LOW       = 3'd3,
		CFG_TOOL_ENABLE    = 3'd4
	} tasp_cfg_idx_t;

	typedef enum logic {
		OP_MOVE    = 1'b0,
		OP_SET_POS = 1'b1
	} tasp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_SX,
		S_DIV_SX,
		S_MUL_SY,
		S_DIV_SY,
		S_MUL_TX,
		S_MUL_TY,
		S_CMP,
		S_DIV_W,
		S_FINISH
	} tasp_state_t;

	typedef struct packed {
		logic                  operation;
		logic [COORD_BITS-1:0] target_x;
		logic [COORD_BITS-1:0] target_y;
	} tasp_in_t;

	typedef struct packed {
		logic                  status;
		logic [STEP_BITS-1:0]  x_steps;
		logic [STEP_BITS-1:0]  y_steps;
		logic                  x_dir;
		logic                  y_dir;
		logic [WIDTH_BITS-1:0] x_high_width;
		logic [WIDTH_BITS-1:0] x_low_width;
		logic [WIDTH_BITS-1:0] y_high_width;
		logic [WIDTH_BITS-1:0] y_low_width;
		logic                  tool_on;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} tasp_out_t;

endpackage

### hw/rtl/tasp_div.sv
module tasp_div
	import tasp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DSR_BITS-1:0] divisor,
	output logic                done,
	output logic [DVD_BITS-1:0] quotient
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DVD_BITS-1:0]     acc_q;
	logic [DSR_BITS-1:0]     rem_q;
	logic [DSR_BITS-1:0]     dsr_q;
	logic [DSR_BITS:0]       trial;
	logic [DSR_BITS:0]       diff;
	logic                    ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, acc_q[DVD_BITS-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? diff[DSR_BITS-1:0] : trial[DSR_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

### hw/rtl/two_axis_move_segment_planner_unit.sv
// sequence: a move request uses S_MUL_SX, S_MUL_SY, S_MUL_TX, S_MUL_TY,
// up to three divider passes (start, 40 quotient bits, done), a compare
// state and a finish state; a step division is skipped when the range
// distance is zero, the width division when the slow axis has no steps
// set-position and rejected requests go straight from idle to finish
// flow: one request at a time; a waiting result holds the next one back
// reset: present position clears to zero, registers take their default values
module two_axis_move_segment_planner_unit
	import tasp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  tasp_in_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tasp_out_t               out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_wdata
);

	tasp_state_t state_q, state_d;

	logic [COORD_BITS-1:0] range_distance_q;
	logic [STEP_BITS-1:0]  range_steps_q;
	logic [BASE_BITS-1:0]  base_high_q;
	logic [BASE_BITS-1:0]  base_low_q;
	logic                  tool_enable_q;

	logic [COORD_BITS-1:0] present_x_q, present_y_q;
	logic [COORD_BITS-1:0] tx_q, ty_q;
	tasp_out_t             res_q;
	tasp_out_t             out_q;
	logic                  out_valid_q;
	logic [DVD_BITS-1:0]   product_q;
	logic [TIME_BITS-1:0]  tx_time_q;
	logic                  slow_y_q;
	logic                  go_q;

	logic                  in_accept;
	logic                  reject;
	logic                  rd_zero;
	logic                  out_free;
	logic                  x_faster;
	logic [STEP_BITS-1:0]  slow_cnt;
	logic                  div_go;
	logic [COORD_BITS-1:0] mag_x, mag_y;
	logic [BASE_BITS:0]    base_sum;
	logic [BASE_BITS-1:0]  half;
	logic [STEP_BITS-1:0]  mul_a;
	logic [COORD_BITS-1:0] mul_b;
	logic [DVD_BITS-1:0]   mul_p;
	logic [DVD_BITS-1:0]   div_dvd;
	logic [DSR_BITS-1:0]   div_dsr;
	logic [DVD_BITS-1:0]   div_q;
	logic [STEP_BITS-1:0]  div_steps;
	logic                  div_start;
	logic                  div_done;
	tasp_out_t             res_init;

	assign in_accept = in_valid && !in_stall;
	assign reject    = (in_data.target_x > range_distance_q) ||
		(in_data.target_y > range_distance_q);
	assign rd_zero   = range_distance_q == '0;
	assign out_free  = !out_valid_q || !out_stall;

	assign mag_x = (tx_q >= present_x_q) ? tx_q - present_x_q : present_x_q - tx_q;
	assign mag_y = (ty_q >= present_y_q) ? ty_q - present_y_q : present_y_q - ty_q;

	assign base_sum = {1'b0, base_high_q} + {1'b0, base_low_q};
	assign half     = BASE_BITS'(base_sum >> 1);

	assign x_faster = tx_time_q > product_q[TIME_BITS-1:0];
	assign slow_cnt = x_faster ? res_q.y_steps : res_q.x_steps;

	// step counts saturate once the quotient leaves the step range
	assign div_steps = (div_q[DVD_BITS-1:STEP_BITS] != '0) ? STEP_MAX
		: div_q[STEP_BITS-1:0];

	// shared multiplier, result registered in product_q (x time in tx_time_q)
	always_comb begin
		case (state_q)
			S_MUL_SY: begin
				mul_a = range_steps_q;
				mul_b = mag_y;
			end
			S_MUL_TX: begin
				mul_a = res_q.x_steps;
				mul_b = COORD_BITS'(half);
			end
			S_MUL_TY: begin
				mul_a = res_q.y_steps;
				mul_b = COORD_BITS'(half);
			end
			default: begin
				mul_a = range_steps_q;
				mul_b = mag_x;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		if (state_q == S_DIV_W) begin
			div_dvd = slow_y_q ? DVD_BITS'(tx_time_q) : DVD_BITS'(product_q[TIME_BITS-1:0]);
			div_dsr = slow_y_q ? DSR_BITS'(res_q.y_steps) : DSR_BITS'(res_q.x_steps);
		end else begin
			div_dvd = product_q;
			div_dsr = range_distance_q;
		end
	end

	assign div_start = go_q;

	tasp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.operation == OP_SET_POS || reject) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_MUL_SX;
					end
				end
			end
			S_MUL_SX: begin
				div_go  = !rd_zero;
				state_d = rd_zero ? S_MUL_SY : S_DIV_SX;
			end
			S_DIV_SX: begin
				if (div_done) state_d = S_MUL_SY;
			end
			S_MUL_SY: begin
				div_go  = !rd_zero;
				state_d = rd_zero ? S_MUL_TX : S_DIV_SY;
			end
			S_DIV_SY: begin
				if (div_done) state_d = S_MUL_TX;
			end
			S_MUL_TX: state_d = S_MUL_TY;
			S_MUL_TY: state_d = S_CMP;
			S_CMP: begin
				div_go  = slow_cnt != '0;
				state_d = (slow_cnt != '0) ? S_DIV_W : S_FINISH;
			end
			S_DIV_W: begin
				if (div_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	// result fields known at acceptance
	always_comb begin
		res_init = '0;
		if (in_data.operation == OP_SET_POS) begin
			res_init.end_x = in_data.target_x;
			res_init.end_y = in_data.target_y;
		end else if (reject) begin
			res_init.status = 1'b1;
			res_init.end_x  = present_x_q;
			res_init.end_y  = present_y_q;
		end else begin
			res_init.x_dir   = in_data.target_x >= present_x_q;
			res_init.y_dir   = in_data.target_y >= present_y_q;
			res_init.tool_on = tool_enable_q;
			res_init.end_x   = in_data.target_x;
			res_init.end_y   = in_data.target_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_distance_q <= RANGE_DISTANCE_RST;
			range_steps_q    <= RANGE_STEPS_RST;
			base_high_q      <= BASE_HIGH_RST;
			base_low_q       <= BASE_LOW_RST;
			tool_enable_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_DISTANCE: range_distance_q <= cfg_wdata[COORD_BITS-1:0];
				CFG_RANGE_STEPS:    range_steps_q    <= cfg_wdata[STEP_BITS-1:0];
				CFG_BASE_HIGH:      base_high_q      <= cfg_wdata[BASE_BITS-1:0];
				CFG_BASE_LOW:       base_low_q       <= cfg_wdata[BASE_BITS-1:0];
				CFG_TOOL_ENABLE:    tool_enable_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_x_q <= '0;
			present_y_q <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= div_go;
			if (in_accept && in_data.operation == OP_SET_POS) begin
				present_x_q <= in_data.target_x;
				present_y_q <= in_data.target_y;
			end else if (state_q == S_CMP) begin
				present_x_q <= tx_q;
				present_y_q <= ty_q;
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				tx_q  <= in_data.target_x;
				ty_q  <= in_data.target_y;
				res_q <= res_init;
			end
			S_MUL_SX, S_MUL_SY: product_q <= mul_p;
			S_DIV_SX: begin
				if (div_done) res_q.x_steps <= div_steps;
			end
			S_DIV_SY: begin
				if (div_done) res_q.y_steps <= div_steps;
			end
			S_MUL_TX: tx_time_q <= mul_p[TIME_BITS-1:0];
			S_MUL_TY: product_q <= mul_p;
			S_CMP: begin
				slow_y_q           <= x_faster;
				res_q.x_high_width <= WIDTH_BITS'(base_high_q);
				res_q.x_low_width  <= WIDTH_BITS'(base_low_q);
				res_q.y_high_width <= WIDTH_BITS'(base_high_q);
				res_q.y_low_width  <= WIDTH_BITS'(base_low_q);
			end
			S_DIV_W: begin
				if (div_done) begin
					if (slow_y_q) begin
						res_q.y_high_width <= div_q[WIDTH_BITS-1:0];
						res_q.y_low_width  <= div_q[WIDTH_BITS-1:0];
					end else begin
						res_q.x_high_width <= div_q[WIDTH_BITS-1:0];
						res_q.x_low_width  <= div_q[WIDTH_BITS-1:0];
					end
				end
			end
			S_FINISH: begin
				if (out_free) out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_done_in_wait : assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_SX || state_q == S_DIV_SY || state_q == S_DIV_W))
		else $error("divider finished outside a wait state");

	a_set_pos_fast : assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.operation == OP_SET_POS |=> state_q == S_FINISH)
		else $error("set position request did not go straight to finish");

	a_reject_clean : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |->
		(out_data.x_steps == '0 && out_data.y_steps == '0 && !out_data.tool_on))
		else $error("rejected request carries move data");

	a_start_idle_div : assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_DIV_SX || state_q == S_DIV_SY || state_q == S_DIV_W))
		else $error("divider started outside a wait state");

endmodule
